### rtl/rkc_pkg.sv
// Shared constants, types and helper functions for the RGBA kernel convolution unit.
`default_nettype none
package rkc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int COEF_BITS  = 16;
  localparam int SLOT_W     = 16;
  localparam int COEF_REG_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int PIX_W      = 32;
  localparam int SUM_W      = 28;
  localparam int PEND_W     = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOT     = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // Control that travels with a window read from the issue stage to the tap stage.
  typedef struct packed {
    logic              first_col;
    logic              left_ok;
    logic              top_ok;
    logic [1:0]        top_lane;
    logic [1:0]        mid_lane;
    logic [1:0]        bot_lane;
    logic              hit_a;
    logic              hit_b;
    logic [1:0]        wr_lane;
    logic [PIX_W-1:0]  wr_data;
    logic              frame_end;
  } rd_side_t;

  function automatic logic [1:0] lane_inc(input logic [1:0] l);
    return (l == 2'd2) ? 2'd0 : l + 2'd1;
  endfunction

  function automatic logic [1:0] lane_dec(input logic [1:0] l);
    return (l == 2'd0) ? 2'd2 : l - 2'd1;
  endfunction

  // Low COEF_BITS of a 16-bit slot, two's complement.
  function automatic logic signed [SLOT_W-1:0] coef_at(input logic [COEF_REG_W-1:0] r,
                                                        input int unsigned j);
    logic [SLOT_W-1:0] raw;
    raw = r[j*SLOT_W +: SLOT_W];
    return signed'(raw);
  endfunction

  function automatic logic [7:0] clamp_ch(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    sh = s >>> 8;
    if (s < 0) begin
      return 8'd0;
    end else if (sh > 255) begin
      return 8'hFF;
    end
    return sh[7:0];
  endfunction

endpackage
`default_nettype wire

### rtl/rgba_kernel_convolution_unit.sv
// Top level of the RGBA 3x3 kernel convolution unit; top and left borders mirror, bottom and right edges repeat.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   cmd_i, in_red/green/blue/alpha_i
//   output    out        out_valid_o / out_stall_i out_red/green/blue/alpha_o, frame_end_o
//   config    in         cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// One beat is taken per clock unless in_stall_o is high; a released result passes the
// read, tap, product, row-sum and output registers. The line memory has one write port
// (a column-word lane) and two read ports (center, right), which sets the one-beat rate.
// Reset clears positions, counters and pipeline valids; the line memory is not cleared.
// in_stall_o rises only when every pipeline stage is full and the output is stalled.
`default_nettype none
module rgba_kernel_convolution_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [rkc_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  wire [rkc_pkg::COEF_REG_W-1:0]       cfg_wdata_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire                                 cmd_i,
  input  wire [7:0]                           in_red_i,
  input  wire [7:0]                           in_green_i,
  input  wire [7:0]                           in_blue_i,
  input  wire [7:0]                           in_alpha_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [7:0]                          out_red_o,
  output logic [7:0]                          out_green_o,
  output logic [7:0]                          out_blue_o,
  output logic [7:0]                          out_alpha_o,
  output logic                                frame_end_o
);
  import rkc_pkg::*;

  // Configuration registers.
  logic [WIDTH_W-1:0]    fw_q;
  logic [HEIGHT_W-1:0]   fh_q;
  logic [COEF_REG_W-1:0] coef_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= WIDTH_W'(640);
      fh_q      <= HEIGHT_W'(480);
      coef_q[0] <= '0;
      coef_q[1] <= COEF_REG_W'(16777216);
      coef_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_WIDTH:  fw_q      <= cfg_wdata_i[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: fh_q      <= cfg_wdata_i[HEIGHT_W-1:0];
        REG_COEF_TOP:     coef_q[0] <= cfg_wdata_i;
        REG_COEF_MID:     coef_q[1] <= cfg_wdata_i;
        REG_COEF_BOT:     coef_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to 1..MAX.
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  always_comb begin
    w_eff = fw_q;
    if (fw_q == '0) w_eff = WIDTH_W'(1);
    else if (fw_q > WIDTH_W'(MAX_WIDTH)) w_eff = WIDTH_W'(MAX_WIDTH);
    h_eff = fh_q;
    if (fh_q == '0) h_eff = HEIGHT_W'(1);
    else if (fh_q > HEIGHT_W'(MAX_HEIGHT)) h_eff = HEIGHT_W'(MAX_HEIGHT);
  end

  // Pipeline valids and stage enables. A stage loads when it is empty or
  // its contents move on in the same cycle.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic en1, en2, en3, en4, en5;
  assign en5 = !out_v_q || !out_stall_i;
  assign en4 = !s4_v_q || en5;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign in_stall_o = !en1;

  // Stream positions. Rows are kept in three lanes of a column word,
  // lane number being the row index modulo three.
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [1:0]        in_lane_q, in_lane_d, out_lane_q, out_lane_d;
  logic              in_done_q, in_done_d;
  logic [PEND_W-1:0] pend_q, pend_d;

  logic              acc, wr, emit, done_new, in_last_col, in_last_row;
  logic              out_last_col, out_last_row;
  logic [PEND_W-1:0] pend_after;
  logic [COL_W-1:0]  right_col;
  rd_side_t          side_d;

  always_comb begin
    acc          = in_valid_i && en1;
    wr           = acc && (cmd_e'(cmd_i) == CMD_PIXEL) && !in_done_q;
    in_last_col  = ({1'b0, in_col_q} + WIDTH_W'(1)) >= w_eff;
    in_last_row  = ({1'b0, in_row_q} + HEIGHT_W'(1)) >= h_eff;
    out_last_col = ({1'b0, out_col_q} + WIDTH_W'(1)) >= w_eff;
    out_last_row = ({1'b0, out_row_q} + HEIGHT_W'(1)) >= h_eff;
    done_new     = in_done_q || (wr && in_last_col && in_last_row);
    pend_after   = pend_q + PEND_W'(wr);
    // A pixel releases the output one line and one pixel behind it.
    emit = acc && (done_new ||
                   (wr && pend_after >= ({1'b0, w_eff} + PEND_W'(2))));

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_lane_d = in_lane_q;
    if (wr) begin
      if (in_last_col) begin
        in_col_d = '0;
        if (in_last_row) begin
          in_row_d  = '0;
          in_lane_d = 2'd0;
        end else begin
          in_row_d  = in_row_q + ROW_W'(1);
          in_lane_d = lane_inc(in_lane_q);
        end
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end

    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_lane_d = out_lane_q;
    in_done_d  = done_new;
    if (emit) begin
      if (out_last_col) begin
        out_col_d = '0;
        if (out_last_row) begin
          out_row_d  = '0;
          out_lane_d = 2'd0;
          in_done_d  = 1'b0;
        end else begin
          out_row_d  = out_row_q + ROW_W'(1);
          out_lane_d = lane_inc(out_lane_q);
        end
      end else begin
        out_col_d = out_col_q + COL_W'(1);
      end
    end
    pend_d = pend_after - PEND_W'(emit);

    // Window geometry: the left column comes from the previous center,
    // except on the first column where it mirrors to column one.
    right_col          = out_last_col ? out_col_q : out_col_q + COL_W'(1);
    side_d.first_col   = (out_col_q == '0);
    side_d.left_ok     = (w_eff > WIDTH_W'(1));
    side_d.top_ok      = (out_row_q != '0) || (h_eff > HEIGHT_W'(1));
    side_d.top_lane    = (out_row_q == '0) ? lane_inc(out_lane_q) : lane_dec(out_lane_q);
    side_d.mid_lane    = out_lane_q;
    side_d.bot_lane    = out_last_row ? out_lane_q : lane_inc(out_lane_q);
    side_d.hit_a       = wr && (in_col_q == out_col_q);
    side_d.hit_b       = wr && (in_col_q == right_col);
    side_d.wr_lane     = in_lane_q;
    side_d.wr_data     = {in_alpha_i, in_blue_i, in_green_i, in_red_i};
    side_d.frame_end   = out_last_col && out_last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_lane_q  <= 2'd0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_lane_q <= 2'd0;
      in_done_q  <= 1'b0;
      pend_q     <= '0;
    end else if (acc) begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_lane_q  <= in_lane_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_lane_q <= out_lane_d;
      in_done_q  <= in_done_d;
      pend_q     <= pend_d;
    end
  end

  // Line memory: one word per column holding three rows. A write updates one
  // lane; two registered reads fetch the center and right columns.
  logic [2:0][PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2:0][PIX_W-1:0] rd_a_q, rd_b_q;
  rd_side_t              side_q;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      line_mem[in_col_q][in_lane_q] <= side_d.wr_data;
    end
    if (en1) begin
      rd_a_q <= line_mem[out_col_q];
      rd_b_q <= line_mem[right_col];
      side_q <= side_d;
    end
  end

  // Stage 2: forward a same-cycle write, pick lanes, form the 3x3 taps.
  logic [2:0][PIX_W-1:0] word_a, word_b;
  logic [1:0]            lane_of [3];
  logic [2:0][23:0]      ctr, rgt, prev_ctr_q;
  logic [2:0][2:0][23:0] tap_d, tap_q;
  logic [7:0]            alpha_d, s2_alpha_q;
  logic                  s2_end_q;
  logic [PIX_W-1:0]      cw;

  always_comb begin
    word_a = rd_a_q;
    word_b = rd_b_q;
    if (side_q.hit_a) word_a[side_q.wr_lane] = side_q.wr_data;
    if (side_q.hit_b) word_b[side_q.wr_lane] = side_q.wr_data;
    lane_of[0] = side_q.top_lane;
    lane_of[1] = side_q.mid_lane;
    lane_of[2] = side_q.bot_lane;
    for (int r = 0; r < 3; r++) begin
      ctr[r] = word_a[lane_of[r]][23:0];
      rgt[r] = word_b[lane_of[r]][23:0];
      tap_d[r][0] = side_q.first_col ? (side_q.left_ok ? rgt[r] : 24'd0) : prev_ctr_q[r];
      tap_d[r][1] = ctr[r];
      tap_d[r][2] = rgt[r];
    end
    // A top row that mirrors outside a one-line frame is skipped.
    if (!side_q.top_ok) tap_d[0] = '0;
    cw      = word_a[side_q.mid_lane];
    alpha_d = cw[31:24];
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_v_q) begin
      prev_ctr_q <= ctr;
    end
    if (en2) begin
      tap_q      <= tap_d;
      s2_alpha_q <= alpha_d;
      s2_end_q   <= side_q.frame_end;
    end
  end

  // Stage 3: one product per tap and channel.
  logic signed [2:0][2:0][2:0][SUM_W-1:0] prod_q;
  logic [7:0] s3_alpha_q;
  logic       s3_end_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          for (int ch = 0; ch < 3; ch++) begin
            prod_q[ch][r][c] <= SUM_W'(coef_at(coef_q[r], c) *
                                       signed'({1'b0, tap_q[r][c][ch*8 +: 8]}));
          end
        end
      end
      s3_alpha_q <= s2_alpha_q;
      s3_end_q   <= s2_end_q;
    end
  end

  // Stage 4: row sums.
  logic signed [2:0][2:0][SUM_W-1:0] row_q;
  logic [7:0] s4_alpha_q;
  logic       s4_end_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int r = 0; r < 3; r++) begin
          row_q[ch][r] <= prod_q[ch][r][0] + prod_q[ch][r][1] + prod_q[ch][r][2];
        end
      end
      s4_alpha_q <= s3_alpha_q;
      s4_end_q   <= s3_end_q;
    end
  end

  // Stage 5: total, clamp and output register.
  logic signed [SUM_W-1:0] tot [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = row_q[ch][0] + row_q[ch][1] + row_q[ch][2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_red_o   <= clamp_ch(tot[0]);
      out_green_o <= clamp_ch(tot[1]);
      out_blue_o  <= clamp_ch(tot[2]);
      out_alpha_o <= s4_alpha_q;
      frame_end_o <= s4_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q  <= emit;
      if (en2) s2_v_q  <= s1_v_q;
      if (en3) s3_v_q  <= s2_v_q;
      if (en4) s4_v_q  <= s3_v_q;
      if (en5) out_v_q <= s4_v_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule
`default_nettype wire

### rtl/rkc_checker.sv
// Port-level checker for the convolution unit and its bind statement.
`default_nettype none
module rkc_port_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_stall_o,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [7:0] out_red_o,
  input wire [7:0] out_green_o,
  input wire [7:0] out_blue_o,
  input wire [7:0] out_alpha_o,
  input wire       frame_end_o
);

  // A stalled output beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // Input backpressure only comes from a stalled, full output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A stalled output beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_red_o) && $stable(out_green_o) &&
      $stable(out_blue_o) && $stable(out_alpha_o) && $stable(frame_end_o))
    else $error("stalled payload changed");

  // The pipeline is empty right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");

endmodule

bind rgba_kernel_convolution_unit rkc_port_checker u_rkc_checker (.*);
`default_nettype wire
